// File: rtl/hsvf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvf_pkg
// Shared types and constants of the hsv color class pixel filter.
// ----------------------------------------------------------------------------
package hsvf_pkg;

  // hue fixed point format
  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_UNIT      = 1 << HUE_FRAC_BITS;
  localparam int HUE_SIXTY     = 60 * HUE_UNIT;
  localparam int QUO_W         = $clog2(HUE_SIXTY + 1);
  localparam int NUM_W         = QUO_W + 8;
  localparam int HUE_W         = $clog2(6 * HUE_SIXTY) + 1;
  localparam int BND_W         = $clog2(767 * HUE_UNIT) + 2;

  // divider pipeline shape
  localparam int DIV_BITS_PER  = 3;
  localparam int DIV_STAGES    = (QUO_W + DIV_BITS_PER - 1) / DIV_BITS_PER;

  // hue of a grey pixel wrapped into the positive range
  localparam int GREY_REST     = 6 * HUE_SIXTY - HUE_UNIT - 5 * HUE_SIXTY;

  // register indexes
  typedef enum logic [2:0] {
    REG_YELLOW_CENTER = 3'd0,
    REG_YELLOW_WINDOW = 3'd1,
    REG_GREEN_CENTER  = 3'd2,
    REG_GREEN_WINDOW  = 3'd3,
    REG_WHITE_FLOOR   = 3'd4,
    REG_BLACK_LIMIT   = 3'd5,
    REG_DARK_FLOOR    = 3'd6,
    REG_SAT_FLOOR     = 3'd7
  } reg_idx_t;

  // color class
  typedef enum logic [2:0] {
    CLS_WHITE,
    CLS_BLACK,
    CLS_YELLOW,
    CLS_GREEN,
    CLS_FULL
  } cls_t;

  typedef struct packed {
    logic [8:0] yellow_hue_center;
    logic [7:0] yellow_hue_window;
    logic [8:0] green_hue_center;
    logic [7:0] green_hue_window;
    logic [7:0] white_value_floor;
    logic [7:0] black_value_limit;
    logic [7:0] dark_value_floor;
    logic [9:0] saturation_floor_milli;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       frame_end_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end_out;
  } pix_out_t;

  typedef struct packed {
    logic             valid;
    logic             frame_end;
    logic [7:0]       mx;
    logic [7:0]       d;
    logic [2:0]       base;
    logic             achrom;
    logic [NUM_W-1:0] num;
  } front_t;

  typedef struct packed {
    logic             valid;
    logic             frame_end;
    logic [7:0]       mx;
    logic [7:0]       d;
    logic [2:0]       base;
    logic             achrom;
    logic [7:0]       rem;
    logic [NUM_W-1:0] num;
    logic [QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic             valid;
    logic             frame_end;
    cls_t             cls;
    logic [7:0]       mx;
    logic [2:0]       sector;
    logic [QUO_W-1:0] rest;
  } cls_stage_t;

endpackage
`default_nettype wire

// File: rtl/hsvf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvf_front
// Max, min, delta and hue sector of a pixel; scaled numerator for the divider.
// ----------------------------------------------------------------------------
module hsvf_front import hsvf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire pix_in_t in_pix,
  output front_t       front_o
);

  front_t     front_r, front_nxt;
  logic [7:0] r, g, b, mx, mn, d, f;
  logic [2:0] base;

  // max, min and the sector relative fraction
  always_comb begin
    r  = in_pix.red_in;
    g  = in_pix.green_in;
    b  = in_pix.blue_in;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    priority if (r == mx) begin
      if (g >= b) begin
        base = 3'd0;
        f    = g - b;
      end else begin
        base = 3'd5;
        f    = d - (b - g);
      end
    end else if (g == mx) begin
      if (b >= r) begin
        base = 3'd2;
        f    = b - r;
      end else begin
        base = 3'd1;
        f    = d - (r - b);
      end
    end else begin
      if (r >= g) begin
        base = 3'd4;
        f    = r - g;
      end else begin
        base = 3'd3;
        f    = d - (g - r);
      end
    end
    front_nxt.valid     = in_valid;
    front_nxt.frame_end = in_pix.frame_end_in;
    front_nxt.mx        = mx;
    front_nxt.d         = d;
    front_nxt.base      = base;
    front_nxt.achrom    = (d == 8'd0);
    front_nxt.num       = NUM_W'(NUM_W'(f) * NUM_W'(HUE_SIXTY));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
    end else begin
      front_r <= front_nxt;
    end
  end

  assign front_o = front_r;

endmodule
`default_nettype wire

// File: rtl/hsvf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvf_div
// Pipelined restoring divider: fraction of the hue sector, a few bits a stage.
// ----------------------------------------------------------------------------
module hsvf_div import hsvf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire front_t front_i,
  output div_t        div_o
);

  div_t stg_r   [DIV_STAGES];
  div_t stg_nxt [DIV_STAGES];
  div_t src     [DIV_STAGES];
  div_t init;

  // entry of the first stage
  always_comb begin
    init.valid     = front_i.valid;
    init.frame_end = front_i.frame_end;
    init.mx        = front_i.mx;
    init.d         = front_i.d;
    init.base      = front_i.base;
    init.achrom    = front_i.achrom;
    init.rem       = front_i.num[NUM_W-1 -: 8];
    init.num       = front_i.num;
    init.quo       = '0;
  end

  // stage sources
  always_comb begin
    src[0] = init;
    for (int s = 1; s < DIV_STAGES; s++) begin
      src[s] = stg_r[s-1];
    end
  end

  // quotient bits of each stage
  always_comb begin
    int         k;
    logic [8:0] tmp;
    for (int s = 0; s < DIV_STAGES; s++) begin
      stg_nxt[s] = src[s];
      for (int j = 0; j < DIV_BITS_PER; j++) begin
        k = s * DIV_BITS_PER + j;
        if (k < QUO_W) begin
          tmp = {stg_nxt[s].rem, stg_nxt[s].num[QUO_W-1-k]};
          if (tmp >= {1'b0, stg_nxt[s].d}) begin
            tmp                      = tmp - {1'b0, stg_nxt[s].d};
            stg_nxt[s].quo[QUO_W-1-k] = 1'b1;
          end
          stg_nxt[s].rem = tmp[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        stg_r[s] <= '0;
      end
    end else begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  assign div_o = stg_r[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: rtl/hsvf_class.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvf_class
// Hue assembly, window and brightness tests, color class decision.
// ----------------------------------------------------------------------------
module hsvf_class import hsvf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire div_t div_i,
  output cls_stage_t cls_o
);

  cls_stage_t              cls_r, cls_nxt;
  logic signed [HUE_W-1:0] hue;
  logic signed [BND_W-1:0] hue_x, y_lo, y_hi, g_lo, g_hi;
  logic signed [BND_W-1:0] yc, yw, gc, gw;
  logic                    in_y, in_g, sat_ok;
  logic [17:0]             sat_lhs, sat_rhs;

  // hue and window bounds
  always_comb begin
    if (div_i.achrom) begin
      hue = -HUE_W'(HUE_UNIT);
    end else begin
      hue = HUE_W'(HUE_W'(div_i.base) * HUE_W'(HUE_SIXTY)) + HUE_W'(div_i.quo);
    end
    hue_x = BND_W'(hue);
    yc    = BND_W'(cfg.yellow_hue_center);
    yw    = BND_W'(cfg.yellow_hue_window);
    gc    = BND_W'(cfg.green_hue_center);
    gw    = BND_W'(cfg.green_hue_window);
    y_lo  = (yc - yw) <<< HUE_FRAC_BITS;
    y_hi  = (yc + yw) <<< HUE_FRAC_BITS;
    g_lo  = (gc - gw) <<< HUE_FRAC_BITS;
    g_hi  = (gc + gw) <<< HUE_FRAC_BITS;
    in_y  = (hue_x > y_lo) && (hue_x < y_hi);
    in_g  = (hue_x > g_lo) && (hue_x < g_hi);
  end

  // saturation test
  always_comb begin
    sat_lhs = 18'(div_i.d) * 18'd1000;
    sat_rhs = 18'(cfg.saturation_floor_milli) * 18'(div_i.mx);
    sat_ok  = sat_lhs > sat_rhs;
  end

  // class decision, first match wins
  always_comb begin
    cls_nxt.valid     = div_i.valid;
    cls_nxt.frame_end = div_i.frame_end;
    cls_nxt.mx        = div_i.mx;
    priority if (div_i.mx > cfg.white_value_floor && !in_y) begin
      cls_nxt.cls = CLS_WHITE;
    end else if (div_i.mx < cfg.black_value_limit) begin
      cls_nxt.cls = CLS_BLACK;
    end else if (in_y) begin
      cls_nxt.cls = (div_i.mx > cfg.dark_value_floor && sat_ok) ? CLS_YELLOW : CLS_WHITE;
    end else if (in_g) begin
      cls_nxt.cls = (div_i.mx > cfg.dark_value_floor) ? CLS_GREEN : CLS_BLACK;
    end else begin
      cls_nxt.cls = CLS_FULL;
    end
    // sector and remainder of the wrapped hue
    priority if (div_i.achrom) begin
      cls_nxt.sector = 3'd5;
      cls_nxt.rest   = QUO_W'(GREY_REST);
    end else if (div_i.quo == QUO_W'(HUE_SIXTY)) begin
      cls_nxt.sector = (div_i.base == 3'd5) ? 3'd0 : div_i.base + 3'd1;
      cls_nxt.rest   = '0;
    end else begin
      cls_nxt.sector = div_i.base;
      cls_nxt.rest   = div_i.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r <= '0;
    end else begin
      cls_r <= cls_nxt;
    end
  end

  assign cls_o = cls_r;

endmodule
`default_nettype wire

// File: rtl/hsvf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvf_back
// Full saturation hsv to rgb, class colors, output register.
// ----------------------------------------------------------------------------
module hsvf_back import hsvf_pkg::*; (
  input  wire cls_stage_t cls_i,
  input  wire logic       clk,
  input  wire logic       rst_n,
  output logic            out_valid,
  output pix_out_t        out_data
);

  localparam int PROD_W = 8 + QUO_W;
  localparam int Y_W    = 12;
  localparam int SHIFT  = HUE_FRAC_BITS + 2;

  logic              mul_valid_r, div_valid_r, out_valid_r;
  logic              mul_fe_r, div_fe_r;
  cls_t              mul_cls_r, div_cls_r;
  logic [7:0]        mul_mx_r, div_mx_r;
  logic [2:0]        mul_sec_r, div_sec_r;
  logic [PROD_W-1:0] prod_t_r, prod_q_r;
  logic [7:0]        t_r, q_r;
  logic [Y_W-1:0]    y_t, y_q;
  logic [23:0]       rt_t, rt_q;
  pix_out_t          out_r, out_nxt;

  // stage a: value times remainder and complement
  always_ff @(posedge clk) begin
    mul_fe_r  <= cls_i.frame_end;
    mul_cls_r <= cls_i.cls;
    mul_mx_r  <= cls_i.mx;
    mul_sec_r <= cls_i.sector;
    prod_t_r  <= PROD_W'(PROD_W'(cls_i.mx) * PROD_W'(cls_i.rest));
    prod_q_r  <= PROD_W'(PROD_W'(cls_i.mx) * PROD_W'(QUO_W'(HUE_SIXTY) - cls_i.rest));
  end

  // stage b: divide by sixty degrees as a shift and a reciprocal of fifteen
  always_comb begin
    y_t  = prod_t_r[SHIFT +: Y_W];
    y_q  = prod_q_r[SHIFT +: Y_W];
    rt_t = (24'(y_t) + 24'd1) * 24'd4369;
    rt_q = (24'(y_q) + 24'd1) * 24'd4369;
  end

  always_ff @(posedge clk) begin
    div_fe_r  <= mul_fe_r;
    div_cls_r <= mul_cls_r;
    div_mx_r  <= mul_mx_r;
    div_sec_r <= mul_sec_r;
    t_r       <= rt_t[23:16];
    q_r       <= rt_q[23:16];
  end

  // stage c: output color
  always_comb begin
    out_nxt.frame_end_out = div_fe_r;
    unique case (div_cls_r)
      CLS_WHITE:  {out_nxt.red_out, out_nxt.green_out, out_nxt.blue_out} = {3{8'hff}};
      CLS_BLACK:  {out_nxt.red_out, out_nxt.green_out, out_nxt.blue_out} = '0;
      CLS_YELLOW: {out_nxt.red_out, out_nxt.green_out, out_nxt.blue_out} =
                    {8'hff, 8'hff, 8'h00};
      CLS_GREEN:  {out_nxt.red_out, out_nxt.green_out, out_nxt.blue_out} =
                    {8'h00, 8'hff, 8'h00};
      default: begin
        unique case (div_sec_r)
          3'd0:    {out_nxt.red_out, out_nxt.green_out, out_nxt.blue_out} =
                     {div_mx_r, t_r, 8'h00};
          3'd1:    {out_nxt.red_out, out_nxt.green_out, out_nxt.blue_out} =
                     {q_r, div_mx_r, 8'h00};
          3'd2:    {out_nxt.red_out, out_nxt.green_out, out_nxt.blue_out} =
                     {8'h00, div_mx_r, t_r};
          3'd3:    {out_nxt.red_out, out_nxt.green_out, out_nxt.blue_out} =
                     {8'h00, q_r, div_mx_r};
          3'd4:    {out_nxt.red_out, out_nxt.green_out, out_nxt.blue_out} =
                     {t_r, 8'h00, div_mx_r};
          default: {out_nxt.red_out, out_nxt.green_out, out_nxt.blue_out} =
                     {div_mx_r, 8'h00, q_r};
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      div_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= cls_i.valid;
      div_valid_r <= mul_valid_r;
      out_valid_r <= div_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: rtl/hsv_color_class_pixel_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_color_class_pixel_filter_core
// Rgb pixel to hsv, color classification and full saturation rgb rebuild.
// ----------------------------------------------------------------------------
// start to out_valid passes the front, divider, class and back registers in that order
// throughput: one item per cycle; busy stays low, the receiver cannot stall
// the hue divider is a 4-stage restoring pipeline, 3 quotient bits per stage
// reset: synchronous active-low rst_n clears all valid bits and loads
// the register defaults; items still in flight at reset are dropped
module hsv_color_class_pixel_filter_core import hsvf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire pix_in_t    in_data,
  output logic            out_valid,
  output pix_out_t        out_data,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [9:0] cfg_wdata
);

  cfg_t       cfg_r, cfg_nxt;
  front_t     front;
  div_t       div_res;
  cls_stage_t cls_res;

  assign busy = 1'b0;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_YELLOW_CENTER: cfg_nxt.yellow_hue_center      = cfg_wdata[8:0];
        REG_YELLOW_WINDOW: cfg_nxt.yellow_hue_window      = cfg_wdata[7:0];
        REG_GREEN_CENTER:  cfg_nxt.green_hue_center       = cfg_wdata[8:0];
        REG_GREEN_WINDOW:  cfg_nxt.green_hue_window       = cfg_wdata[7:0];
        REG_WHITE_FLOOR:   cfg_nxt.white_value_floor      = cfg_wdata[7:0];
        REG_BLACK_LIMIT:   cfg_nxt.black_value_limit      = cfg_wdata[7:0];
        REG_DARK_FLOOR:    cfg_nxt.dark_value_floor       = cfg_wdata[7:0];
        REG_SAT_FLOOR:     cfg_nxt.saturation_floor_milli = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.yellow_hue_center      <= 9'd60;
      cfg_r.yellow_hue_window      <= 8'd40;
      cfg_r.green_hue_center       <= 9'd165;
      cfg_r.green_hue_window       <= 8'd40;
      cfg_r.white_value_floor      <= 8'd191;
      cfg_r.black_value_limit      <= 8'd13;
      cfg_r.dark_value_floor       <= 8'd25;
      cfg_r.saturation_floor_milli <= 10'd900;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // pipeline
  hsvf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_pix   (in_data),
    .front_o  (front)
  );

  hsvf_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .front_i (front),
    .div_o   (div_res)
  );

  hsvf_class u_class (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .div_i (div_res),
    .cls_o (cls_res)
  );

  hsvf_back u_back (
    .cls_i     (cls_res),
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // every accepted item comes out after the pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##9 out_valid)
    else $error("item lost in pipeline");

  // no result without an item accepted one pipeline latency before
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 9))
    else $error("result without item");

  // frame mark travels with its pixel
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.frame_end_out == $past(in_data.frame_end_in, 9)))
    else $error("frame end mark misaligned");
`endif

endmodule
`default_nettype wire
